/* rtl/core/kf2s_pkg.sv */
// kf2s_pkg: word format, register ids, opcodes and the step microprogram
// of the two-state Kalman filter. No dependencies.
package kf2s_pkg;

    localparam int WORD_BITS = 56;
    localparam int FRAC_BITS = 24;
    localparam int HALF_BITS = (WORD_BITS + 1) / 2;
    localparam int MAG_BITS  = 2 * HALF_BITS;
    localparam int PROD_BITS = 2 * MAG_BITS;
    localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;
    localparam int SAT_BITS  = (PROD_BITS > QUO_BITS) ? PROD_BITS : QUO_BITS;
    localparam int CNT_BITS  = $clog2(QUO_BITS + 1);

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_END
    } op_t;

    typedef enum logic [2:0] {
        CFG_T00,
        CFG_T01,
        CFG_T10,
        CFG_T11,
        CFG_QV,
        CFG_QR,
        CFG_MNOISE
    } cfg_idx_t;

    typedef enum logic [4:0] {
        R_T00, R_T01, R_T10, R_T11, R_QV, R_QR, R_MNOISE, R_ONE,
        R_SV, R_SR, R_C00, R_C01, R_C10, R_C11, R_Z, R_T1,
        R_T2, R_X0M, R_X1M, R_A, R_B, R_C, R_D, R_P00,
        R_P01, R_P10, R_P11, R_S, R_K0, R_K1, R_OM, R_E
    } reg_id_t;

    typedef struct packed {
        op_t     op;
        reg_id_t src_a;
        reg_id_t src_b;
        reg_id_t dst;
    } instr_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_req_t;

    localparam int PROG_LEN = 48;
    localparam int PC_BITS  = $clog2(PROG_LEN);

    localparam instr_t PROG [PROG_LEN] = '{
        '{OP_MUL, R_T00, R_SV,  R_T1},
        '{OP_MUL, R_T01, R_SR,  R_T2},
        '{OP_ADD, R_T1,  R_T2,  R_X0M},
        '{OP_MUL, R_T10, R_SV,  R_T1},
        '{OP_MUL, R_T11, R_SR,  R_T2},
        '{OP_ADD, R_T1,  R_T2,  R_X1M},
        '{OP_MUL, R_T00, R_C00, R_T1},
        '{OP_MUL, R_T01, R_C10, R_T2},
        '{OP_ADD, R_T1,  R_T2,  R_A},
        '{OP_MUL, R_T00, R_C01, R_T1},
        '{OP_MUL, R_T01, R_C11, R_T2},
        '{OP_ADD, R_T1,  R_T2,  R_B},
        '{OP_MUL, R_T10, R_C00, R_T1},
        '{OP_MUL, R_T11, R_C10, R_T2},
        '{OP_ADD, R_T1,  R_T2,  R_C},
        '{OP_MUL, R_T10, R_C01, R_T1},
        '{OP_MUL, R_T11, R_C11, R_T2},
        '{OP_ADD, R_T1,  R_T2,  R_D},
        '{OP_MUL, R_A,   R_T00, R_T1},
        '{OP_MUL, R_B,   R_T01, R_T2},
        '{OP_ADD, R_T1,  R_T2,  R_T1},
        '{OP_ADD, R_T1,  R_QV,  R_P00},
        '{OP_MUL, R_A,   R_T10, R_T1},
        '{OP_MUL, R_B,   R_T11, R_T2},
        '{OP_ADD, R_T1,  R_T2,  R_P01},
        '{OP_MUL, R_C,   R_T00, R_T1},
        '{OP_MUL, R_D,   R_T01, R_T2},
        '{OP_ADD, R_T1,  R_T2,  R_P10},
        '{OP_MUL, R_C,   R_T10, R_T1},
        '{OP_MUL, R_D,   R_T11, R_T2},
        '{OP_ADD, R_T1,  R_T2,  R_T1},
        '{OP_ADD, R_T1,  R_QR,  R_P11},
        '{OP_ADD, R_P00, R_MNOISE, R_S},
        '{OP_DIV, R_P00, R_S,   R_K0},
        '{OP_DIV, R_P10, R_S,   R_K1},
        '{OP_SUB, R_ONE, R_K0,  R_OM},
        '{OP_MUL, R_OM,  R_P00, R_C00},
        '{OP_MUL, R_OM,  R_P01, R_C01},
        '{OP_MUL, R_K1,  R_P00, R_T1},
        '{OP_SUB, R_P10, R_T1,  R_C10},
        '{OP_MUL, R_K1,  R_P01, R_T1},
        '{OP_SUB, R_P11, R_T1,  R_C11},
        '{OP_SUB, R_Z,   R_X0M, R_E},
        '{OP_MUL, R_K0,  R_E,   R_T1},
        '{OP_ADD, R_X0M, R_T1,  R_SV},
        '{OP_MUL, R_K1,  R_E,   R_T1},
        '{OP_ADD, R_X1M, R_T1,  R_SR},
        '{OP_END, R_T1,  R_T1,  R_T1}
    };

    // whole + thousandths/1000, rounded at FRAC_BITS, saturated
    function automatic word_t konst(input longint unsigned whole,
                                    input longint unsigned thou);
        logic [127:0] v;
        v = (128'(whole) << FRAC_BITS)
            + ((128'(thou) << FRAC_BITS) + 128'd500) / 128'd1000;
        if (v > 128'(WORD_MAX)) begin
            v = 128'(WORD_MAX);
        end
        return word_t'(v[WORD_BITS-1:0]);
    endfunction

    localparam word_t RST_ONE    = konst(64'd1, 64'd0);
    localparam word_t RST_T01    =
        word_t'(((128'd1 << FRAC_BITS) + 128'd2000) / 128'd4000);
    localparam word_t RST_QR     = konst(64'd1082, 64'd323);
    localparam word_t RST_MNOISE = konst(64'd0, 64'd40);
    localparam word_t RST_C01    = konst(64'd160, 64'd0);
    localparam word_t RST_C11    = konst(64'd641082, 64'd323);

endpackage

/* rtl/core/kf2s_alu.sv */
// kf2s_alu: shared saturating add/sub, 4-pass fixed-point multiply and
// bit-serial divide. Depends on kf2s_pkg.
module kf2s_alu (
    input  logic               aclk,
    input  logic               aresetn,
    input  kf2s_pkg::alu_req_t req,
    input  kf2s_pkg::word_t    opd_a,
    input  kf2s_pkg::word_t    opd_b,
    output logic               done,
    output kf2s_pkg::word_t    result
);

    localparam int W  = kf2s_pkg::WORD_BITS;
    localparam int H  = kf2s_pkg::HALF_BITS;
    localparam int MB = kf2s_pkg::MAG_BITS;
    localparam int PB = kf2s_pkg::PROD_BITS;
    localparam int QB = kf2s_pkg::QUO_BITS;
    localparam int SB = kf2s_pkg::SAT_BITS;
    localparam int CB = kf2s_pkg::CNT_BITS;
    localparam int F  = kf2s_pkg::FRAC_BITS;

    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_MUL  = 5'b00010,
        A_MFIN = 5'b00100,
        A_DIV  = 5'b01000,
        A_DFIN = 5'b10000
    } alu_state_t;

    alu_state_t      state_reg, state_next;
    logic            done_reg, done_next;
    kf2s_pkg::word_t res_reg, res_next;
    logic            neg_reg, neg_next;
    logic [MB-1:0]   mx_reg, mx_next, my_reg, my_next;
    logic [PB-1:0]   acc_reg, acc_next;
    logic [MB-1:0]   pp_reg, pp_next;
    logic [1:0]      sh_reg, sh_next;
    logic [CB-1:0]   cnt_reg, cnt_next;
    logic [W:0]      rem_reg, rem_next;
    logic [QB-1:0]   dvd_reg, dvd_next, quo_reg, quo_next;

    logic [W:0]      trial;
    logic [PB-1:0]   pp_shift, rounded;

    function automatic logic [MB-1:0] mag(input kf2s_pkg::word_t v);
        logic [MB-1:0] e;
        e = MB'(v);
        return v[W-1] ? (~e + MB'(1)) : e;
    endfunction

    function automatic kf2s_pkg::word_t sat_add(input kf2s_pkg::word_t a,
                                                input kf2s_pkg::word_t b,
                                                input logic sub);
        logic signed [W:0] s;
        s = sub ? ((W+1)'(a) - (W+1)'(b)) : ((W+1)'(a) + (W+1)'(b));
        if (s[W] != s[W-1]) begin
            return s[W] ? kf2s_pkg::WORD_MIN : kf2s_pkg::WORD_MAX;
        end
        return s[W-1:0];
    endfunction

    function automatic kf2s_pkg::word_t from_mag(input logic neg,
                                                 input logic [SB-1:0] m);
        logic [SB-1:0] lim;
        lim = SB'(kf2s_pkg::WORD_MAX);
        if (neg) begin
            if (m > lim + SB'(1)) begin
                return kf2s_pkg::WORD_MIN;
            end
            return kf2s_pkg::word_t'(~m[W-1:0] + W'(1));
        end
        if (m > lim) begin
            return kf2s_pkg::WORD_MAX;
        end
        return kf2s_pkg::word_t'(m[W-1:0]);
    endfunction

    always_comb begin
        case (sh_reg)
            2'd0:    pp_shift = PB'(pp_reg);
            2'd1:    pp_shift = PB'(pp_reg) << H;
            2'd2:    pp_shift = PB'(pp_reg) << (2 * H);
            default: pp_shift = '0;
        endcase
    end

    assign rounded = (acc_reg + (PB'(1) << (F - 1))) >> F;
    assign trial   = {rem_reg[W-1:0], dvd_reg[QB-1]};

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        neg_next   = neg_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        acc_next   = acc_reg;
        pp_next    = pp_reg;
        sh_next    = sh_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    neg_next = opd_a[W-1] ^ opd_b[W-1];
                    mx_next  = mag(opd_a);
                    my_next  = mag(opd_b);
                    acc_next = '0;
                    cnt_next = '0;
                    rem_next = '0;
                    quo_next = '0;
                    dvd_next = {mx_next[W-1:0], {F{1'b0}}};
                    case (req.op)
                        kf2s_pkg::OP_ADD: begin
                            res_next  = sat_add(opd_a, opd_b, 1'b0);
                            done_next = 1'b1;
                        end
                        kf2s_pkg::OP_SUB: begin
                            res_next  = sat_add(opd_a, opd_b, 1'b1);
                            done_next = 1'b1;
                        end
                        kf2s_pkg::OP_MUL: state_next = A_MUL;
                        kf2s_pkg::OP_DIV: state_next = A_DIV;
                        default: done_next = 1'b1;
                    endcase
                end
            end
            A_MUL: begin
                case (cnt_reg[1:0])
                    2'd0: begin
                        pp_next = MB'(mx_reg[H-1:0] * my_reg[H-1:0]);
                        sh_next = 2'd0;
                    end
                    2'd1: begin
                        pp_next = MB'(mx_reg[H-1:0] * my_reg[MB-1:H]);
                        sh_next = 2'd1;
                    end
                    2'd2: begin
                        pp_next = MB'(mx_reg[MB-1:H] * my_reg[H-1:0]);
                        sh_next = 2'd1;
                    end
                    default: begin
                        pp_next = MB'(mx_reg[MB-1:H] * my_reg[MB-1:H]);
                        sh_next = 2'd2;
                    end
                endcase
                if (cnt_reg != '0) begin
                    acc_next = acc_reg + pp_shift;
                end
                cnt_next = cnt_reg + CB'(1);
                if (cnt_reg == CB'(4)) begin
                    state_next = A_MFIN;
                end
            end
            A_MFIN: begin
                res_next   = from_mag(neg_reg, SB'(rounded));
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            A_DIV: begin
                if (trial >= (W+1)'(my_reg)) begin
                    rem_next = trial - (W+1)'(my_reg);
                    quo_next = {quo_reg[QB-2:0], 1'b1};
                end else begin
                    rem_next = trial;
                    quo_next = {quo_reg[QB-2:0], 1'b0};
                end
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + CB'(1);
                if (cnt_reg == CB'(QB - 1)) begin
                    state_next = A_DFIN;
                end
            end
            A_DFIN: begin
                res_next   = (my_reg == '0) ? '0 : from_mag(neg_reg, SB'(quo_reg));
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        neg_reg <= neg_next;
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        acc_reg <= acc_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* rtl/core/kalman_filter_two_state.sv */
// kalman_filter_two_state: sequencer, register file and result register
// of the two-state Kalman filter. Depends on kf2s_pkg and kf2s_alu.
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+-------------------
//  input    | s_measurement                      | s_valid / s_ready
//  result   | m_est_value, m_est_rate            | m_valid / m_ready
//  config   | cfg_index, cfg_wdata               | cfg_wr_en
//
// One transaction runs a 47-op microprogram on the shared ALU: 26 multiplies,
// 2 divides and 19 add/sub, each awaited before the next is issued. s_ready
// is high only while idle. A pending result does not block the next
// transaction; a finished step waits for the result register to free up.
// Reset loads default registers and the initial state and covariance.
module kalman_filter_two_state (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  kf2s_pkg::word_t       s_measurement,
    output logic                  m_valid,
    input  logic                  m_ready,
    output kf2s_pkg::word_t       m_est_value,
    output kf2s_pkg::word_t       m_est_rate,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_index,
    input  logic [kf2s_pkg::WORD_BITS-1:0] cfg_wdata
);

    localparam int W  = kf2s_pkg::WORD_BITS;
    localparam int PB = kf2s_pkg::PC_BITS;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_OUT   = 4'b1000
    } seq_state_t;

    seq_state_t       state_reg, state_next;
    logic [PB-1:0]    pc_reg, pc_next;
    logic             m_valid_reg;
    kf2s_pkg::word_t  m_val_reg, m_rate_reg;

    kf2s_pkg::word_t t00_reg, t01_reg, t10_reg, t11_reg, qv_reg, qr_reg, mn_reg;
    kf2s_pkg::word_t sv_reg, sr_reg, c00_reg, c01_reg, c10_reg, c11_reg, z_reg;
    kf2s_pkg::word_t t1_reg, t2_reg, x0m_reg, x1m_reg, a_reg, b_reg, c_reg, d_reg;
    kf2s_pkg::word_t p00_reg, p01_reg, p10_reg, p11_reg, s_reg, k0_reg, k1_reg;
    kf2s_pkg::word_t om_reg, e_reg;

    kf2s_pkg::instr_t   instr;
    kf2s_pkg::alu_req_t alu_req;
    kf2s_pkg::word_t    opd_a, opd_b, alu_res;
    logic               alu_done, wb, out_free;
    kf2s_pkg::word_t    cfg_u;

    function automatic kf2s_pkg::word_t rd(input kf2s_pkg::reg_id_t id);
        case (id)
            kf2s_pkg::R_T00:    return t00_reg;
            kf2s_pkg::R_T01:    return t01_reg;
            kf2s_pkg::R_T10:    return t10_reg;
            kf2s_pkg::R_T11:    return t11_reg;
            kf2s_pkg::R_QV:     return qv_reg;
            kf2s_pkg::R_QR:     return qr_reg;
            kf2s_pkg::R_MNOISE: return mn_reg;
            kf2s_pkg::R_ONE:    return kf2s_pkg::RST_ONE;
            kf2s_pkg::R_SV:     return sv_reg;
            kf2s_pkg::R_SR:     return sr_reg;
            kf2s_pkg::R_C00:    return c00_reg;
            kf2s_pkg::R_C01:    return c01_reg;
            kf2s_pkg::R_C10:    return c10_reg;
            kf2s_pkg::R_C11:    return c11_reg;
            kf2s_pkg::R_Z:      return z_reg;
            kf2s_pkg::R_T1:     return t1_reg;
            kf2s_pkg::R_T2:     return t2_reg;
            kf2s_pkg::R_X0M:    return x0m_reg;
            kf2s_pkg::R_X1M:    return x1m_reg;
            kf2s_pkg::R_A:      return a_reg;
            kf2s_pkg::R_B:      return b_reg;
            kf2s_pkg::R_C:      return c_reg;
            kf2s_pkg::R_D:      return d_reg;
            kf2s_pkg::R_P00:    return p00_reg;
            kf2s_pkg::R_P01:    return p01_reg;
            kf2s_pkg::R_P10:    return p10_reg;
            kf2s_pkg::R_P11:    return p11_reg;
            kf2s_pkg::R_S:      return s_reg;
            kf2s_pkg::R_K0:     return k0_reg;
            kf2s_pkg::R_K1:     return k1_reg;
            kf2s_pkg::R_OM:     return om_reg;
            kf2s_pkg::R_E:      return e_reg;
            default:            return '0;
        endcase
    endfunction

    assign instr    = kf2s_pkg::PROG[pc_reg];
    assign opd_a    = rd(instr.src_a);
    assign opd_b    = rd(instr.src_b);
    assign wb       = (state_reg == S_WAIT) && alu_done;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign cfg_u    = {1'b0, cfg_wdata[W-2:0]};

    always_comb begin
        alu_req.start = (state_reg == S_ISSUE) && (instr.op != kf2s_pkg::OP_END);
        alu_req.op    = instr.op;
    end

    kf2s_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opd_a   (opd_a),
        .opd_b   (opd_b),
        .done    (alu_done),
        .result  (alu_res)
    );

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    pc_next    = '0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE: begin
                state_next = (instr.op == kf2s_pkg::OP_END) ? S_OUT : S_WAIT;
            end
            S_WAIT: begin
                if (alu_done) begin
                    pc_next    = pc_reg + PB'(1);
                    state_next = S_ISSUE;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
            t00_reg     <= kf2s_pkg::RST_ONE;
            t01_reg     <= kf2s_pkg::RST_T01;
            t10_reg     <= '0;
            t11_reg     <= kf2s_pkg::RST_ONE;
            qv_reg      <= '0;
            qr_reg      <= kf2s_pkg::RST_QR;
            mn_reg      <= kf2s_pkg::RST_MNOISE;
            sv_reg      <= '0;
            sr_reg      <= '0;
            c00_reg     <= kf2s_pkg::RST_MNOISE;
            c01_reg     <= kf2s_pkg::RST_C01;
            c10_reg     <= kf2s_pkg::RST_C01;
            c11_reg     <= kf2s_pkg::RST_C11;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (kf2s_pkg::cfg_idx_t'(cfg_index))
                    kf2s_pkg::CFG_T00:    t00_reg <= cfg_wdata;
                    kf2s_pkg::CFG_T01:    t01_reg <= cfg_wdata;
                    kf2s_pkg::CFG_T10:    t10_reg <= cfg_wdata;
                    kf2s_pkg::CFG_T11:    t11_reg <= cfg_wdata;
                    kf2s_pkg::CFG_QV:     qv_reg  <= cfg_u;
                    kf2s_pkg::CFG_QR:     qr_reg  <= cfg_u;
                    kf2s_pkg::CFG_MNOISE: mn_reg  <= cfg_u;
                    default: ;
                endcase
            end
            if (wb) begin
                case (instr.dst)
                    kf2s_pkg::R_SV:  sv_reg  <= alu_res;
                    kf2s_pkg::R_SR:  sr_reg  <= alu_res;
                    kf2s_pkg::R_C00: c00_reg <= alu_res;
                    kf2s_pkg::R_C01: c01_reg <= alu_res;
                    kf2s_pkg::R_C10: c10_reg <= alu_res;
                    kf2s_pkg::R_C11: c11_reg <= alu_res;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            z_reg <= s_measurement;
        end
        if (state_reg == S_OUT && out_free) begin
            m_val_reg  <= sv_reg;
            m_rate_reg <= sr_reg;
        end
        if (wb) begin
            case (instr.dst)
                kf2s_pkg::R_T1:  t1_reg  <= alu_res;
                kf2s_pkg::R_T2:  t2_reg  <= alu_res;
                kf2s_pkg::R_X0M: x0m_reg <= alu_res;
                kf2s_pkg::R_X1M: x1m_reg <= alu_res;
                kf2s_pkg::R_A:   a_reg   <= alu_res;
                kf2s_pkg::R_B:   b_reg   <= alu_res;
                kf2s_pkg::R_C:   c_reg   <= alu_res;
                kf2s_pkg::R_D:   d_reg   <= alu_res;
                kf2s_pkg::R_P00: p00_reg <= alu_res;
                kf2s_pkg::R_P01: p01_reg <= alu_res;
                kf2s_pkg::R_P10: p10_reg <= alu_res;
                kf2s_pkg::R_P11: p11_reg <= alu_res;
                kf2s_pkg::R_S:   s_reg   <= alu_res;
                kf2s_pkg::R_K0:  k0_reg  <= alu_res;
                kf2s_pkg::R_K1:  k1_reg  <= alu_res;
                kf2s_pkg::R_OM:  om_reg  <= alu_res;
                kf2s_pkg::R_E:   e_reg   <= alu_res;
                default: ;
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_est_value = m_val_reg;
    assign m_est_rate  = m_rate_reg;

endmodule

/* tb/testbench.sv */
// Testbench for kalman_filter_two_state: directed table then randomized
// configuration phases, estimates checked against a fixed-point predictor or the
// table's typed values. Depends on kf2s_pkg and the kalman_filter_two_state RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WB = kf2s_pkg::WORD_BITS;
    localparam int FB = kf2s_pkg::FRAC_BITS;
    localparam logic [2:0] NO_REG = 3'd7;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASE_ITEMS = 100;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    kf2s_pkg::word_t s_measurement = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    kf2s_pkg::word_t m_est_value, m_est_rate;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [WB-1:0] cfg_wdata = '0;

    always #1 aclk = ~aclk;

    kalman_filter_two_state DUT (.*);

    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;
    typedef struct {
        row_kind_t       kind;
        logic [2:0]      idx;
        logic [WB-1:0]   data;
        logic            typed;
        kf2s_pkg::word_t exp_value;
        kf2s_pkg::word_t exp_rate;
    } row_t;

    row_t  stim_table[$];
    kf2s_pkg::word_t exp_value_q[$];
    kf2s_pkg::word_t exp_rate_q[$];
    int    failures = 0;
    int    idle_cycles = 0;
    int    burst_left = 0;

    // filter state and registers mirrored by the predictor
    kf2s_pkg::word_t f_t00, f_t01, f_t10, f_t11, f_qv, f_qr, f_rn;
    kf2s_pkg::word_t f_sv, f_sr, f_c00, f_c01, f_c10, f_c11;

    function automatic logic [127:0] magnitude(kf2s_pkg::word_t v);
        longint sv;
        sv = v;
        return (sv < 0) ? 128'(-sv) : 128'(sv);
    endfunction

    function automatic kf2s_pkg::word_t clamp_mag(logic neg, logic [127:0] m);
        logic [127:0] lim;
        lim = 128'(kf2s_pkg::WORD_MAX);
        if (neg) begin
            if (m > lim + 1) m = lim + 1;
            return kf2s_pkg::word_t'(-m);
        end
        if (m > lim) m = lim;
        return kf2s_pkg::word_t'(m);
    endfunction

    function automatic kf2s_pkg::word_t q_mul(kf2s_pkg::word_t a, kf2s_pkg::word_t b);
        logic [127:0] p;
        p = magnitude(a) * magnitude(b);
        p = (p + (128'd1 << (FB - 1))) >> FB;
        return clamp_mag(a[WB-1] ^ b[WB-1], p);
    endfunction

    function automatic kf2s_pkg::word_t q_div(kf2s_pkg::word_t n, kf2s_pkg::word_t d);
        logic [127:0] y;
        y = magnitude(d);
        if (y == 0) return '0;
        return clamp_mag(n[WB-1] ^ d[WB-1], (magnitude(n) << FB) / y);
    endfunction

    function automatic kf2s_pkg::word_t q_add(kf2s_pkg::word_t a, kf2s_pkg::word_t b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > longint'(kf2s_pkg::WORD_MAX)) return kf2s_pkg::WORD_MAX;
        if (s < longint'(kf2s_pkg::WORD_MIN)) return kf2s_pkg::WORD_MIN;
        return kf2s_pkg::word_t'(s);
    endfunction

    function automatic kf2s_pkg::word_t q_sub(kf2s_pkg::word_t a, kf2s_pkg::word_t b);
        longint s;
        s = longint'(a) - longint'(b);
        if (s > longint'(kf2s_pkg::WORD_MAX)) return kf2s_pkg::WORD_MAX;
        if (s < longint'(kf2s_pkg::WORD_MIN)) return kf2s_pkg::WORD_MIN;
        return kf2s_pkg::word_t'(s);
    endfunction

    function automatic void filter_reset();
        f_t00 = kf2s_pkg::RST_ONE;  f_t01 = kf2s_pkg::RST_T01;
        f_t10 = '0;  f_t11 = kf2s_pkg::RST_ONE;
        f_qv = '0;  f_qr = kf2s_pkg::RST_QR;  f_rn = kf2s_pkg::RST_MNOISE;
        f_sv = '0;  f_sr = '0;
        f_c00 = kf2s_pkg::RST_MNOISE;  f_c01 = kf2s_pkg::RST_C01;
        f_c10 = kf2s_pkg::RST_C01;  f_c11 = kf2s_pkg::RST_C11;
    endfunction

    function automatic void filter_config(logic [2:0] idx, logic [WB-1:0] data);
        kf2s_pkg::word_t u;
        u = kf2s_pkg::word_t'({1'b0, data[WB-2:0]});
        case (idx)
            kf2s_pkg::CFG_T00: f_t00 = kf2s_pkg::word_t'(data);
            kf2s_pkg::CFG_T01: f_t01 = kf2s_pkg::word_t'(data);
            kf2s_pkg::CFG_T10: f_t10 = kf2s_pkg::word_t'(data);
            kf2s_pkg::CFG_T11: f_t11 = kf2s_pkg::word_t'(data);
            kf2s_pkg::CFG_QV: f_qv = u;
            kf2s_pkg::CFG_QR: f_qr = u;
            kf2s_pkg::CFG_MNOISE: f_rn = u;
            default: ;
        endcase
    endfunction

    function automatic void filter_step(kf2s_pkg::word_t z, output kf2s_pkg::word_t ev,
                                        output kf2s_pkg::word_t er);
        kf2s_pkg::word_t x0m, x1m, a, b, c, d, p00m, p01m, p10m, p11m, s, k0, k1, om, e;
        x0m = q_add(q_mul(f_t00, f_sv), q_mul(f_t01, f_sr));
        x1m = q_add(q_mul(f_t10, f_sv), q_mul(f_t11, f_sr));
        a = q_add(q_mul(f_t00, f_c00), q_mul(f_t01, f_c10));
        b = q_add(q_mul(f_t00, f_c01), q_mul(f_t01, f_c11));
        c = q_add(q_mul(f_t10, f_c00), q_mul(f_t11, f_c10));
        d = q_add(q_mul(f_t10, f_c01), q_mul(f_t11, f_c11));
        p00m = q_add(q_add(q_mul(a, f_t00), q_mul(b, f_t01)), f_qv);
        p01m = q_add(q_mul(a, f_t10), q_mul(b, f_t11));
        p10m = q_add(q_mul(c, f_t00), q_mul(d, f_t01));
        p11m = q_add(q_add(q_mul(c, f_t10), q_mul(d, f_t11)), f_qr);
        s = q_add(p00m, f_rn);
        k0 = q_div(p00m, s);
        k1 = q_div(p10m, s);
        om = q_sub(kf2s_pkg::RST_ONE, k0);
        f_c00 = q_mul(om, p00m);
        f_c01 = q_mul(om, p01m);
        f_c10 = q_sub(p10m, q_mul(k1, p00m));
        f_c11 = q_sub(p11m, q_mul(k1, p01m));
        e = q_sub(z, x0m);
        f_sv = q_add(x0m, q_mul(k0, e));
        f_sr = q_add(x1m, q_mul(k1, e));
        ev = f_sv;
        er = f_sr;
    endfunction

    function automatic logic [WB-1:0] rand_word();
        return WB'({$urandom, $urandom});
    endfunction

    function automatic logic [WB-1:0] rand_small(int bits);
        return WB'($signed(64'({$urandom, $urandom}) << (64 - bits)) >>> (64 - bits));
    endfunction

    function automatic logic [WB-1:0] pick_reg(logic [2:0] idx);
        case ($urandom_range(0, 9))
            0: return kf2s_pkg::WORD_MIN;
            1: return kf2s_pkg::WORD_MAX;
            2: return '0;
            3: return rand_word();
            default: begin
                case (idx)
                    kf2s_pkg::CFG_T00, kf2s_pkg::CFG_T11:
                        return kf2s_pkg::RST_ONE + rand_small(20);
                    kf2s_pkg::CFG_T01: return rand_small(16);
                    kf2s_pkg::CFG_T10: return rand_small(10);
                    default: return rand_small(36) & {1'b0, {(WB-1){1'b1}}};
                endcase
            end
        endcase
    endfunction

    function automatic kf2s_pkg::word_t pick_meas();
        case ($urandom_range(0, 9))
            0, 1: return rand_word();
            2: return $urandom_range(0, 1) ? kf2s_pkg::WORD_MAX : kf2s_pkg::WORD_MIN;
            3: return rand_small(12);
            default: return rand_small(32);
        endcase
    endfunction

    task automatic wait_drained();
        while (exp_value_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [WB-1:0] data);
        wait_drained();
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(posedge aclk);
        filter_config(idx, data);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_item(kf2s_pkg::word_t z, logic typed, kf2s_pkg::word_t tv,
                             kf2s_pkg::word_t tr);
        kf2s_pkg::word_t ev, er;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30)) @(negedge aclk);
        end
        burst_left--;
        s_valid = 1'b1;
        s_measurement = z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        filter_step(z, ev, er);
        exp_value_q.push_back(typed ? tv : ev);
        exp_rate_q.push_back(typed ? tr : er);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic add_cfg(logic [2:0] idx, logic [WB-1:0] data);
        stim_table.push_back('{ROW_CFG, idx, data, 1'b0, '0, '0});
    endtask

    task automatic add_item(kf2s_pkg::word_t z, logic typed, kf2s_pkg::word_t tv,
                            kf2s_pkg::word_t tr);
        stim_table.push_back('{ROW_ITEM, '0, z, typed, tv, tr});
    endtask

    always @(negedge aclk) begin
        case (($time / 400) % 3)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (exp_value_q.size() == 0) begin
                $display("%0t: unexpected result value=%h rate=%h", $time, m_est_value,
                         m_est_rate);
                failures++;
            end else begin
                if (m_est_value !== exp_value_q[0]) begin
                    $display("%0t: est_value expected %h actual %h", $time,
                             exp_value_q[0], m_est_value);
                    failures++;
                end
                if (m_est_rate !== exp_rate_q[0]) begin
                    $display("%0t: est_rate expected %h actual %h", $time,
                             exp_rate_q[0], m_est_rate);
                    failures++;
                end
                void'(exp_value_q.pop_front());
                void'(exp_rate_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int   sent;
        logic [2:0] r;
        filter_reset();
        // directed: zero state stays zero, extremes, zero divisor, bad index
        add_item('0, 1'b1, '0, '0);
        add_item(kf2s_pkg::WORD_MAX, 1'b0, '0, '0);
        add_item(kf2s_pkg::WORD_MIN, 1'b0, '0, '0);
        add_item(kf2s_pkg::word_t'(1), 1'b0, '0, '0);
        add_item(kf2s_pkg::word_t'(-1), 1'b0, '0, '0);
        add_item(kf2s_pkg::RST_ONE, 1'b0, '0, '0);
        for (int i = kf2s_pkg::CFG_T00; i <= kf2s_pkg::CFG_MNOISE; i++) add_cfg(3'(i), '0);
        add_item(kf2s_pkg::WORD_MAX, 1'b1, '0, '0);
        add_item(kf2s_pkg::WORD_MIN, 1'b1, '0, '0);
        add_cfg(NO_REG, kf2s_pkg::WORD_MAX);
        add_item(kf2s_pkg::word_t'(12345), 1'b1, '0, '0);
        for (int i = kf2s_pkg::CFG_T00; i <= kf2s_pkg::CFG_MNOISE; i++) begin
            add_cfg(3'(i), kf2s_pkg::WORD_MAX);
        end
        add_item(kf2s_pkg::WORD_MAX, 1'b0, '0, '0);
        add_item(kf2s_pkg::WORD_MIN, 1'b0, '0, '0);
        for (int i = kf2s_pkg::CFG_T00; i <= kf2s_pkg::CFG_MNOISE; i++) begin
            add_cfg(3'(i), kf2s_pkg::WORD_MIN);
        end
        add_item(kf2s_pkg::WORD_MAX, 1'b0, '0, '0);
        add_item('0, 1'b0, '0, '0);
        add_cfg(kf2s_pkg::CFG_T00, kf2s_pkg::RST_ONE);
        add_cfg(kf2s_pkg::CFG_T01, kf2s_pkg::RST_T01);
        add_cfg(kf2s_pkg::CFG_T10, '0);
        add_cfg(kf2s_pkg::CFG_T11, kf2s_pkg::RST_ONE);
        add_cfg(kf2s_pkg::CFG_QV, {1'b1, {(WB-1){1'b0}}});
        add_cfg(kf2s_pkg::CFG_QR, kf2s_pkg::RST_QR);
        add_cfg(kf2s_pkg::CFG_MNOISE, kf2s_pkg::RST_MNOISE);
        add_item(kf2s_pkg::word_t'(-5000000), 1'b0, '0, '0);
        add_item(kf2s_pkg::word_t'(7000000), 1'b0, '0, '0);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_CFG) begin
                write_reg(stim_table[i].idx, stim_table[i].data);
            end else begin
                send_item(kf2s_pkg::word_t'(stim_table[i].data), stim_table[i].typed,
                          stim_table[i].exp_value, stim_table[i].exp_rate);
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            for (int i = kf2s_pkg::CFG_T00; i <= NO_REG; i++) begin
                r = 3'(i);
                if ($urandom_range(0, 2) != 0 || sent == 0) write_reg(r, pick_reg(r));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(pick_meas(), 1'b0, '0, '0);
                sent++;
            end
        end

        wait_drained();
        repeat (500) @(negedge aclk);
        if (failures == 0 && exp_value_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/kf2s_pkg.sv
rtl/core/kf2s_alu.sv
rtl/core/kalman_filter_two_state.sv
tb/testbench.sv
